// ----- src/irfp_pkg.sv -----
// ----------------------------------------------------------------------------
// irfp_pkg
// Types and constants shared by the IMU response frame parser modules.
// ----------------------------------------------------------------------------
package irfp_pkg;

    // Longest segment; bytes past the active segment length keep old values
    localparam int SEG_MAX_BYTES = 41;

    localparam logic [1:0] LAYOUT_INT16     = 2'd0;
    localparam logic [1:0] LAYOUT_FLOAT     = 2'd1;
    localparam logic [1:0] LAYOUT_FLOAT_EXT = 2'd2;

    localparam logic [5:0] LEN_INT16     = 6'd21;
    localparam logic [5:0] LEN_FLOAT     = 6'd29;
    localparam logic [5:0] LEN_FLOAT_EXT = 6'd41;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ACCEL = 2'd1;
    localparam logic [1:0] KIND_GYRO  = 2'd2;
    localparam logic [1:0] KIND_BOTH  = 2'd3;

    typedef logic [SEG_MAX_BYTES-1:0][7:0] seg_bytes_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] sample_seq;
        logic [63:0] timestamp;
        logic [2:0]  sample_flags;
        logic [31:0] temperature;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] accel_z;
        logic [31:0] gyro_x;
        logic [31:0] gyro_y;
        logic [31:0] gyro_z;
        logic [7:0]  packet_state;
        logic        last_in_packet;
    } sample_t;

    // Parser to decoder: segment complete and its context
    typedef struct packed {
        logic       emit;
        logic       last;
        logic [7:0] state_byte;
        logic [1:0] layout;
    } seg_ctrl_t;

    function automatic logic [5:0] seg_len(input logic [1:0] layout);
        logic [5:0] len;
        case (layout)
            LAYOUT_INT16: len = LEN_INT16;
            LAYOUT_FLOAT: len = LEN_FLOAT;
            default:      len = LEN_FLOAT_EXT;
        endcase
        return len;
    endfunction

endpackage

// ----- src/irfp_parser.sv -----
// ----------------------------------------------------------------------------
// irfp_parser
// Frame phase tracking, payload segmentation and segment byte assembly.
// ----------------------------------------------------------------------------
module irfp_parser
    import irfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  byte_item_t item,
    input  logic [1:0] layout,
    output seg_bytes_t seg_bytes,
    output seg_ctrl_t  ctrl
);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_STATE    = 3'd1;
    localparam logic [2:0] PH_SIZE_HI  = 3'd2;
    localparam logic [2:0] PH_SIZE_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;
    localparam logic [2:0] PH_CHECKSUM = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] seen_reg, seen_next;
    logic [5:0]  idx_reg, idx_next;
    logic [5:0]  len0_reg, len0_next;
    logic [16:0] end_reg, end_next;
    logic [7:0]  state_reg, state_next;
    seg_bytes_t  buf_reg, buf_next;

    logic [15:0] size_full;
    logic [16:0] end_plus;
    logic [5:0]  cur_len;
    logic        emit;
    logic        last;

    assign size_full = {size_reg[15:8], item.data_byte};
    assign end_plus  = end_reg + {11'd0, len0_reg};
    assign cur_len   = seg_len(layout);

    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        seen_next  = seen_reg;
        idx_next   = idx_reg;
        len0_next  = len0_reg;
        end_next   = end_reg;
        state_next = state_reg;
        buf_next   = buf_reg;
        emit       = 1'b0;
        last       = 1'b0;
        if (step)
        begin
            if (item.frame_start)
            begin
                // drop any frame in progress; this byte is the header
                phase_next = PH_STATE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_STATE:
                    begin
                        state_next = item.data_byte;
                        phase_next = PH_SIZE_HI;
                    end
                    PH_SIZE_HI:
                    begin
                        size_next  = {item.data_byte, 8'h00};
                        phase_next = PH_SIZE_LO;
                    end
                    PH_SIZE_LO:
                    begin
                        size_next  = size_full;
                        seen_next  = 16'd0;
                        idx_next   = 6'd0;
                        len0_next  = cur_len;
                        end_next   = {11'd0, cur_len};
                        phase_next = (size_full == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        buf_next[idx_reg] = item.data_byte;
                        seen_next = seen_reg + 16'd1;
                        if (({1'b0, idx_reg} + 7'd1) >= {1'b0, cur_len})
                        begin
                            idx_next = 6'd0;
                            // end_reg is the payload offset where segment k ends
                            if (end_reg <= {1'b0, size_reg})
                            begin
                                emit     = 1'b1;
                                last     = end_plus > {1'b0, size_reg};
                                end_next = end_plus;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 6'd1;
                        end
                        if (seen_next >= size_reg)
                            phase_next = PH_CHECKSUM;
                    end
                    PH_CHECKSUM:
                    begin
                        phase_next = PH_HEADER;
                    end
                    default:
                    begin
                        phase_next = PH_STATE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            size_reg  <= '0;
            seen_reg  <= '0;
            idx_reg   <= '0;
            len0_reg  <= LEN_INT16;
            end_reg   <= '0;
            state_reg <= '0;
            buf_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            seen_reg  <= seen_next;
            idx_reg   <= idx_next;
            len0_reg  <= len0_next;
            end_reg   <= end_next;
            state_reg <= state_next;
            buf_reg   <= buf_next;
        end
    end

    assign seg_bytes       = buf_next;
    assign ctrl.emit       = emit;
    assign ctrl.last       = last;
    assign ctrl.state_byte = state_reg;
    assign ctrl.layout     = layout;

endmodule

// ----- src/irfp_decode.sv -----
// ----------------------------------------------------------------------------
// irfp_decode
// Field extraction and accel/gyro routing for one completed segment.
// ----------------------------------------------------------------------------
module irfp_decode
    import irfp_pkg::*;
(
    input  seg_bytes_t seg_bytes,
    input  seg_ctrl_t  ctrl,
    output sample_t    sample
);

    logic [2:0]  flags;
    logic [1:0]  kind;
    logic [31:0] temp;
    logic [2:0][31:0] vec;
    logic [2:0][31:0] extra;
    logic [2:0][31:0] accel;
    logic [2:0][31:0] gyro;
    logic [15:0] half;

    assign flags = seg_bytes[12][2:0];
    assign kind  = flags[1:0];

    always_comb
    begin
        half = {seg_bytes[13], seg_bytes[14]};
        if (ctrl.layout == LAYOUT_INT16)
        begin
            temp = {{16{half[15]}}, half};
            for (int i = 0; i < 3; i++)
            begin
                half     = {seg_bytes[15 + 2 * i], seg_bytes[16 + 2 * i]};
                vec[i]   = {{16{half[15]}}, half};
                extra[i] = '0;
            end
        end
        else
        begin
            temp = {seg_bytes[16], seg_bytes[15], seg_bytes[14], seg_bytes[13]};
            for (int i = 0; i < 3; i++)
            begin
                vec[i] = {seg_bytes[20 + 4 * i], seg_bytes[19 + 4 * i],
                          seg_bytes[18 + 4 * i], seg_bytes[17 + 4 * i]};
                if (ctrl.layout == LAYOUT_FLOAT)
                    extra[i] = '0;
                else
                    extra[i] = {seg_bytes[32 + 4 * i], seg_bytes[31 + 4 * i],
                                seg_bytes[30 + 4 * i], seg_bytes[29 + 4 * i]};
            end
        end
    end

    always_comb
    begin
        accel = '0;
        gyro  = '0;
        case (kind)
            KIND_ACCEL: accel = vec;
            KIND_GYRO:  gyro  = vec;
            KIND_BOTH:
            begin
                // int16 layout has no room for both vectors: leave them zero
                if (ctrl.layout != LAYOUT_INT16)
                begin
                    gyro  = vec;
                    accel = extra;
                end
            end
            default: ;
        endcase
    end

    assign sample.sample_seq     = {seg_bytes[0], seg_bytes[1], seg_bytes[2], seg_bytes[3]};
    assign sample.timestamp      = {seg_bytes[4], seg_bytes[5], seg_bytes[6], seg_bytes[7],
                                    seg_bytes[8], seg_bytes[9], seg_bytes[10], seg_bytes[11]};
    assign sample.sample_flags   = flags;
    assign sample.temperature    = temp;
    assign sample.accel_x        = accel[0];
    assign sample.accel_y        = accel[1];
    assign sample.accel_z        = accel[2];
    assign sample.gyro_x         = gyro[0];
    assign sample.gyro_y         = gyro[1];
    assign sample.gyro_z         = gyro[2];
    assign sample.packet_state   = ctrl.state_byte;
    assign sample.last_in_packet = ctrl.last;

endmodule

// ----- src/irfp_out_queue.sv -----
// ----------------------------------------------------------------------------
// irfp_out_queue
// Result register with a skid entry behind it.
// ----------------------------------------------------------------------------
module irfp_out_queue
    import irfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output sample_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    sample_t main_reg, main_next;
    sample_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into full queue");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !pop |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost while stalled");

    a_main_drains_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && !pop |=> main_valid_reg)
        else $error("result dropped without being taken");

endmodule

// ----- src/imu_response_frame_parser.sv -----
// ----------------------------------------------------------------------------
// imu_response_frame_parser
// Byte-wise parser of IMU response frames into decoded samples.
// ----------------------------------------------------------------------------
//
//   channel   | handshake          | payload
//   ----------+--------------------+------------------------------------------
//   byte      | byte_valid/stall   | byte_item_t: data_byte, frame_start
//   sample    | sample_valid/stall | sample_t: id, timestamp, flags, vectors
//   cfg       | cfg_valid/ready    | cfg_data: segment_layout (2 bits)
//
// One byte per cycle sustained while the skid entry is free. A byte is held
// in the input register; the parser then advances and, on the last byte of a
// complete segment, the decoded sample lands in the result register or skid entry.
// Reset (rst_n, asynchronous) clears phase, counters and segment bytes.
// A sample that meets a stalled result register goes to a skid entry so bytes
// keep flowing; the byte channel stalls only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module imu_response_frame_parser
    import irfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_data,
    output logic       sample_valid,
    input  logic       sample_stall,
    output sample_t    sample_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    logic       layout_reg;
    logic [1:0] layout_q_reg;
    logic       in_valid_reg, in_valid_next;
    byte_item_t in_item_reg;
    logic       accept;
    logic       advance;
    logic       step;
    logic       queue_full;
    seg_bytes_t seg_bytes;
    seg_ctrl_t  ctrl;
    sample_t    decoded;

    // Layout register: always ready; write it only while no request is in flight
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_q_reg <= LAYOUT_INT16;
            layout_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            layout_q_reg <= cfg_data;
            layout_reg   <= 1'b1;
        end
    end

    // Advance the held byte whenever a possible sample has a slot to go
    assign advance    = !queue_full;
    assign step       = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Hold the request payload until the parser takes it
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= byte_data;
    end

    irfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .layout    (layout_q_reg),
        .seg_bytes (seg_bytes),
        .ctrl      (ctrl)
    );

    irfp_decode u_decode (
        .seg_bytes (seg_bytes),
        .ctrl      (ctrl),
        .sample    (decoded)
    );

    irfp_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ctrl.emit),
        .push_data (decoded),
        .full      (queue_full),
        .out_valid (sample_valid),
        .out_stall (sample_stall),
        .out_data  (sample_data)
    );

    // A segment can only finish on a byte that the parser is taking
    a_emit_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> step)
        else $error("segment emitted without a byte");

    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_valid_reg && queue_full)
        else $error("byte channel stalled with no held request");

    a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> layout_reg && layout_q_reg == $past(cfg_data))
        else $error("layout write not captured");

endmodule
